>>> sv/rrtd_pkg.sv
// ---------------------------------------------------------------------------
// rrtd_pkg
// shared constants and types for the round-robin tick delay scheduler
// ---------------------------------------------------------------------------
package rrtd_pkg;

  localparam int NUM_TASKS = 5;
  localparam int TICK_BITS = 32;
  localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_DELAY = 1'b1
  } cmd_t;

  localparam logic [TASK_W-1:0] IDLE_TASK  = '0;
  localparam logic [TASK_W-1:0] FIRST_TASK = TASK_W'(1);

  typedef logic [NUM_TASKS-1:0][TICK_BITS-1:0] wake_arr_t;

  typedef struct packed {
    logic [NUM_TASKS-1:0] blocked;
    logic [TASK_W-1:0]    cur;
    logic [TICK_BITS-1:0] tick;
    logic                 wake_we;
    logic [TICK_BITS-1:0] wake_wdata;
  } upd_t;

endpackage

>>> sv/rrtd_if.sv
// ---------------------------------------------------------------------------
// rrtd_req_if / rrtd_rsp_if
// valid/ready channels for scheduler events and scheduling results
// ---------------------------------------------------------------------------
interface rrtd_req_if;
  import rrtd_pkg::*;

  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  logic [TICK_BITS-1:0] delay_ticks;

  modport source (output valid, command, delay_ticks, input ready);
  modport sink   (input valid, command, delay_ticks, output ready);
endinterface

interface rrtd_rsp_if;
  import rrtd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TASK_W-1:0]    running_task;
  logic [TICK_BITS-1:0] tick_now;
  logic [NUM_TASKS-1:0] ready_mask;

  modport source (output valid, running_task, tick_now, ready_mask, input ready);
  modport sink   (input valid, running_task, tick_now, ready_mask, output ready);
endinterface

>>> sv/rrtd_pick.sv
// ---------------------------------------------------------------------------
// rrtd_pick
// event update: tick and wake matching or delay blocking, then the
// round-robin pick of the next task
// ---------------------------------------------------------------------------
module rrtd_pick (
  input  rrtd_pkg::cmd_t                 command,
  input  logic [rrtd_pkg::TICK_BITS-1:0] delay_ticks,
  input  logic [rrtd_pkg::NUM_TASKS-1:0] blocked,
  input  rrtd_pkg::wake_arr_t            wake,
  input  logic [rrtd_pkg::TASK_W-1:0]    cur,
  input  logic [rrtd_pkg::TICK_BITS-1:0] tick,
  output rrtd_pkg::upd_t                 upd
);
  import rrtd_pkg::*;

  logic [NUM_TASKS-1:0] blocked_ev;
  logic [TICK_BITS-1:0] tick_ev;
  logic                 wake_we;
  logic [TICK_BITS-1:0] wake_wdata;
  logic [TASK_W-1:0]    pick;
  logic [TASK_W:0]      cand;
  logic [TASK_W-1:0]    cand_idx;

  always_comb begin
    blocked_ev = blocked;
    tick_ev    = tick;
    wake_we    = 1'b0;
    wake_wdata = tick + delay_ticks;
    case (command)
      CMD_TICK: begin
        tick_ev = tick + TICK_BITS'(1);
        for (int t = 0; t < NUM_TASKS; t++) begin
          if (blocked[t] && (wake[t] == tick_ev)) begin
            blocked_ev[t] = 1'b0;
          end
        end
      end
      CMD_DELAY: begin
        if (cur != IDLE_TASK) begin
          blocked_ev[cur] = 1'b1;
          wake_we         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // descending scan so the nearest ready task after cur wins
  always_comb begin
    pick     = IDLE_TASK;
    cand     = '0;
    cand_idx = '0;
    for (int s = NUM_TASKS; s >= 1; s--) begin
      cand = {1'b0, cur} + (TASK_W+1)'(s);
      if (cand >= (TASK_W+1)'(NUM_TASKS)) begin
        cand = cand - (TASK_W+1)'(NUM_TASKS);
      end
      cand_idx = cand[TASK_W-1:0];
      if ((cand_idx != IDLE_TASK) && !blocked_ev[cand_idx]) begin
        pick = cand_idx;
      end
    end
  end

  assign upd.blocked    = blocked_ev;
  assign upd.cur        = pick;
  assign upd.tick       = tick_ev;
  assign upd.wake_we    = wake_we;
  assign upd.wake_wdata = wake_wdata;

endmodule

>>> sv/round_robin_tick_delay_scheduler.sv
// ---------------------------------------------------------------------------
// round_robin_tick_delay_scheduler
// round-robin task scheduler with tick-counted delays
//
// req carries one event per word: command tick advances the tick counter and
// wakes blocked tasks whose wake tick equals the new count; command delay
// blocks the running user task until tick + delay_ticks (a delay from the
// idle task is dropped). rsp returns one word per event: the task picked to
// run next, the tick count after the event and the ready mask.
// The event is registered on accept; its result is registered when the event
// advances, that is once rsp is empty or taken. One event per cycle is
// sustained while rsp is taken: the wake compares and the pick of the next
// task sit between the event register and the result register.
// If the receiver stalls, the result register holds and the event register
// fills; req.ready then drops until rsp is taken.
// Reset: every task ready, task 1 current, tick counter zero, both channels
// empty. Wake ticks are only meaningful while their task is blocked.
// ---------------------------------------------------------------------------
module round_robin_tick_delay_scheduler (
  input logic        clk,
  input logic        rst,
  rrtd_req_if.sink   req,
  rrtd_rsp_if.source rsp
);
  import rrtd_pkg::*;

  logic                 in_valid;
  cmd_t                 in_cmd;
  logic [TICK_BITS-1:0] in_delay;

  logic [NUM_TASKS-1:0] blocked;
  wake_arr_t            wake;
  logic [TASK_W-1:0]    cur;
  logic [TICK_BITS-1:0] tick;

  logic                 advance;
  upd_t                 upd;

  assign advance   = in_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  rrtd_pick u_pick (
    .command     (in_cmd),
    .delay_ticks (in_delay),
    .blocked     (blocked),
    .wake        (wake),
    .cur         (cur),
    .tick        (tick),
    .upd         (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_cmd   <= req.command;
      in_delay <= req.delay_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked <= '0;
      cur     <= FIRST_TASK;
      tick    <= '0;
    end else if (advance) begin
      blocked <= upd.blocked;
      cur     <= upd.cur;
      tick    <= upd.tick;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && upd.wake_we) begin
      wake[cur] <= upd.wake_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (advance) begin
      rsp.running_task <= upd.cur;
      rsp.tick_now     <= upd.tick;
      rsp.ready_mask   <= ~upd.blocked;
    end
  end

  a_idle_never_blocked: assert property (@(posedge clk) disable iff (rst)
    !blocked[0])
    else $error("idle task marked blocked");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    cur < TASK_W'(NUM_TASKS))
    else $error("current task index out of range");

  a_picked_is_ready: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.ready_mask[rsp.running_task])
    else $error("picked task is not ready");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (advance && in_cmd == CMD_TICK) |=> tick == $past(tick) + TICK_BITS'(1))
    else $error("tick counter did not advance on tick");

  a_delay_keeps_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && in_cmd == CMD_DELAY) |=> $stable(tick))
    else $error("tick counter moved on delay");

endmodule
